>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SDSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdss assertion failed");

// next-cycle implication
`define SDSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdss assertion failed");

`endif

>>> hw/rtl/sdss_pkg.sv
// ---------------------------------------------------------------------------
// sdss_pkg
// Constants, codes, types and helpers of the sixel DCS stream splitter.
// ---------------------------------------------------------------------------
package sdss_pkg;

  // header store and counters
  localparam int HEADER_BYTES = 32;
  localparam int HDR_AW       = $clog2(HEADER_BYTES);
  localparam int HC_W         = $clog2(HEADER_BYTES + 1);
  localparam int PC_BITS      = 24;
  localparam logic [PC_BITS-1:0] PC_MASK = '1;

  // configuration
  localparam int LIMIT_W = 24;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'h100000;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_PAYLOAD_LIMIT = '0;

  // parser modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_CSI    = 3'd2;
  localparam logic [2:0] MODE_DCS    = 3'd3;
  localparam logic [2:0] MODE_SIX    = 3'd4;
  localparam logic [2:0] MODE_SIXESC = 3'd5;

  // characters
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_SUB   = 8'h1a;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_FIN_LO = 8'h40;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_C = 8'h63;
  localparam logic [7:0] CH_LOW_Q = 8'h71;
  localparam logic [7:0] CH_FIN_HI = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_DCS   = 8'h90;
  localparam logic [7:0] CH_CSI   = 8'h9b;
  localparam logic [7:0] CH_ST    = 8'h9c;

  // result routes
  localparam logic [1:0] ROUTE_VT    = 2'd0;
  localparam logic [1:0] ROUTE_PAY   = 2'd1;
  localparam logic [1:0] ROUTE_EVENT = 2'd2;

  // events
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_COMPLETE  = 3'd1;
  localparam logic [2:0] EV_OVERFLOW  = 3'd2;
  localparam logic [2:0] EV_CANCEL    = 3'd3;
  localparam logic [2:0] EV_CTRL_DONE = 3'd4;
  localparam logic [2:0] EV_RESET     = 3'd5;

  // emit source select
  localparam logic [1:0] SEL_PRE   = 2'd0;
  localparam logic [1:0] SEL_FLUSH = 2'd1;
  localparam logic [1:0] SEL_POST  = 2'd2;

  // one result item
  typedef struct packed {
    logic [1:0] route;
    logic [7:0] out_byte;
    logic [2:0] event_res;
  } res_t;

  // result plan of the item being accepted
  typedef struct packed {
    logic [2:0]      npre;
    logic [HC_W-1:0] nflush;
    logic            post_v;
    logic            wr2;
  } plan_t;

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              emit;
    logic [1:0]        sel;
    logic [1:0]        pre_idx;
    logic [HDR_AW-1:0] rd_addr;
    logic              wr2;
    logic              last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    plan_t plan;
    logic  out_free;
  } sts_t;

  function automatic res_t vt_res(input logic [7:0] b);
    res_t r;
    r.route     = ROUTE_VT;
    r.out_byte  = b;
    r.event_res = EV_NONE;
    return r;
  endfunction

  function automatic res_t pay_res(input logic [7:0] b);
    res_t r;
    r.route     = ROUTE_PAY;
    r.out_byte  = b;
    r.event_res = EV_NONE;
    return r;
  endfunction

  function automatic res_t ev_res(input logic [2:0] e);
    res_t r;
    r.route     = ROUTE_EVENT;
    r.out_byte  = 8'h00;
    r.event_res = e;
    return r;
  endfunction

endpackage

>>> hw/rtl/sdss_in_if.sv
// ---------------------------------------------------------------------------
// sdss_in_if
// Input channel: one terminal byte and the VT ground flag per item.
// ---------------------------------------------------------------------------
interface sdss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       vt_ground;

  modport source (output valid, output data_byte, output vt_ground, input ready);
  modport sink   (input valid, input data_byte, input vt_ground, output ready);
endinterface

>>> hw/rtl/sdss_out_if.sv
// ---------------------------------------------------------------------------
// sdss_out_if
// Result channel: routed byte or event, with a last-of-item marker.
// ---------------------------------------------------------------------------
interface sdss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] route;
  logic [7:0] out_byte;
  logic [2:0] event_res;
  logic       last;

  modport source (output valid, output route, output out_byte, output event_res,
                  output last, input ready);
  modport sink   (input valid, input route, input out_byte, input event_res,
                  input last, output ready);
endinterface

>>> hw/rtl/sdss_ram.sv
// ---------------------------------------------------------------------------
// sdss_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sdss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sdss_ctrl.sv
// ---------------------------------------------------------------------------
// sdss_ctrl
// Sequencer: takes one item, then steps through its results one at a time.
// ---------------------------------------------------------------------------
module sdss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdss_pkg::sts_t  sts,
  output sdss_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_FL   = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;
  localparam logic [2:0] S_WR2  = 3'd5;

  logic [2:0]                      state_r, state_nxt;
  logic [2:0]                      npre_r, npre_nxt;
  logic [sdss_pkg::HC_W-1:0]       nflush_r, nflush_nxt;
  logic                            post_r, post_nxt;
  logic [1:0]                      k_r, k_nxt;
  logic [sdss_pkg::HDR_AW-1:0]     f_r, f_nxt;
  logic [sdss_pkg::HC_W-1:0]       f_ext;
  logic                            pre_last;
  logic                            fl_last;

  assign f_ext    = {{(sdss_pkg::HC_W - sdss_pkg::HDR_AW){1'b0}}, f_r};
  assign pre_last = (({1'b0, k_r} + 3'd1) == npre_r);
  assign fl_last  = ((f_ext + {{(sdss_pkg::HC_W-1){1'b0}}, 1'b1}) == nflush_r);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    npre_nxt    = npre_r;
    nflush_nxt  = nflush_r;
    post_nxt    = post_r;
    k_nxt       = k_r;
    f_nxt       = f_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.pre_idx = k_r;
    cmd.rd_addr = f_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          npre_nxt   = sts.plan.npre;
          nflush_nxt = sts.plan.nflush;
          post_nxt   = sts.plan.post_v;
          k_nxt      = '0;
          f_nxt      = '0;
          if (sts.plan.wr2) begin
            state_nxt = S_WR2;
          end else if (sts.plan.npre != 3'd0) begin
            state_nxt = S_PRE;
          end else if (sts.plan.nflush != '0) begin
            state_nxt = S_RD;
          end else if (sts.plan.post_v) begin
            state_nxt = S_POST;
          end
        end
      end
      S_PRE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = sdss_pkg::SEL_PRE;
          cmd.last = pre_last && (nflush_r == '0) && !post_r;
          if (pre_last) begin
            if (nflush_r != '0) begin
              state_nxt = S_RD;
            end else if (post_r) begin
              state_nxt = S_POST;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      S_RD: begin
        // header RAM read latency
        state_nxt = S_FL;
      end
      S_FL: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = sdss_pkg::SEL_FLUSH;
          cmd.last = fl_last && !post_r;
          if (fl_last) begin
            state_nxt = post_r ? S_POST : S_IDLE;
          end else begin
            f_nxt     = f_r + {{(sdss_pkg::HDR_AW-1){1'b0}}, 1'b1};
            state_nxt = S_RD;
          end
        end
      end
      S_POST: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = sdss_pkg::SEL_POST;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WR2: begin
        // second header byte after ESC P or ESC [; a cancel event may follow
        cmd.wr2   = 1'b1;
        state_nxt = (npre_r != 3'd0) ? S_PRE : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      npre_r   <= '0;
      nflush_r <= '0;
      post_r   <= 1'b0;
      k_r      <= '0;
      f_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      npre_r   <= npre_nxt;
      nflush_r <= nflush_nxt;
      post_r   <= post_nxt;
      k_r      <= k_nxt;
      f_r      <= f_nxt;
    end
  end

endmodule

>>> hw/rtl/sdss_dp.sv
// ---------------------------------------------------------------------------
// sdss_dp
// Datapath: parser state, header RAM, result plan, output register, config.
// ---------------------------------------------------------------------------
module sdss_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [7:0]                     data_byte,
  input  logic                           vt_ground,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     route,
  output logic [7:0]                     out_byte,
  output logic [2:0]                     event_res,
  output logic                           last,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sdss_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [sdss_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [sdss_pkg::CFG_DW-1:0]    cfg_prdata,
  input  sdss_pkg::cmd_t                 cmd,
  output sdss_pkg::sts_t                 sts
);

  // parser state
  logic [2:0]                      mode_r, mode_nxt;
  logic [sdss_pkg::HC_W-1:0]       hc_r, hc_nxt;
  logic [sdss_pkg::PC_BITS-1:0]    pc_r, pc_nxt;
  logic                            drop_r, drop_nxt;
  logic [sdss_pkg::LIMIT_W-1:0]    limit_r;

  // latched plan of the current item
  sdss_pkg::res_t                  pre_r [4];
  sdss_pkg::res_t                  post_r;
  logic                            fl_pay_r;
  logic [7:0]                      byte_r;

  // output register
  logic                            out_valid_r;
  sdss_pkg::res_t                  out_res_r;
  logic                            out_last_r;

  // decode results
  sdss_pkg::res_t                  pre_d [4];
  sdss_pkg::res_t                  post_d;
  logic [2:0]                      npre_d;
  logic [sdss_pkg::HC_W-1:0]       nflush_d;
  logic                            fl_pay_d;
  logic                            post_v_d;
  logic                            wr_en_d;
  logic [sdss_pkg::HDR_AW-1:0]     wr_addr_d;
  logic [7:0]                      wr_data_d;
  logic                            wr2_d;

  // escape handling shared by escape and sixel-escape modes
  sdss_pkg::res_t                  esc_res [3];
  logic [1:0]                      esc_n;
  logic [2:0]                      esc_mode;
  logic                            esc_hdr;

  // helpers
  logic [7:0]                      b;
  logic [31:0]                     lim_ext;
  logic [sdss_pkg::PC_BITS-1:0]    eff;
  logic [sdss_pkg::HC_W-1:0]       hc_inc;
  logic [sdss_pkg::PC_BITS-1:0]    hc_inc_ext;
  logic                            pa_full;
  logic                            pa_emit;
  logic                            pa_drop;
  logic [sdss_pkg::PC_BITS-1:0]    pa_pc;
  logic [2:0]                      close_ev;
  logic                            is_param;

  // RAM ports
  logic                            ram_we;
  logic [sdss_pkg::HDR_AW-1:0]     ram_waddr;
  logic [7:0]                      ram_wdata;
  logic [7:0]                      ram_rdata;

  // config decode
  logic                            cfg_wr;
  logic                            cfg_sel_limit;

  assign b          = data_byte;
  assign lim_ext    = {{(32 - sdss_pkg::LIMIT_W){1'b0}}, limit_r};
  assign eff        = (lim_ext < {{(32 - sdss_pkg::PC_BITS){1'b0}}, sdss_pkg::PC_MASK}) ?
                      lim_ext[sdss_pkg::PC_BITS-1:0] : sdss_pkg::PC_MASK;
  assign hc_inc     = hc_r + {{(sdss_pkg::HC_W-1){1'b0}}, 1'b1};
  assign hc_inc_ext = {{(sdss_pkg::PC_BITS - sdss_pkg::HC_W){1'b0}}, hc_inc};
  assign is_param   = ((b >= sdss_pkg::CH_ZERO) && (b <= sdss_pkg::CH_NINE)) ||
                      (b == sdss_pkg::CH_SEMI);

  // payload append: emit while under the limit, else start dropping
  assign pa_full  = (pc_r >= eff);
  assign pa_emit  = !drop_r && !pa_full;
  assign pa_drop  = drop_r || pa_full;
  assign pa_pc    = pa_emit ? (pc_r + {{(sdss_pkg::PC_BITS-1){1'b0}}, 1'b1}) :
                    (drop_r ? pc_r : '0);
  assign close_ev = pa_drop ? sdss_pkg::EV_OVERFLOW : sdss_pkg::EV_COMPLETE;

  // byte after ESC
  always_comb begin
    esc_res[0] = sdss_pkg::vt_res(b);
    esc_res[1] = sdss_pkg::vt_res(b);
    esc_res[2] = sdss_pkg::vt_res(b);
    esc_n      = 2'd0;
    esc_mode   = sdss_pkg::MODE_ESC;
    esc_hdr    = 1'b0;
    if ((b == sdss_pkg::CH_CAN) || (b == sdss_pkg::CH_SUB)) begin
      esc_n    = 2'd1;
      esc_mode = sdss_pkg::MODE_NORMAL;
    end else if (b == sdss_pkg::CH_DEL) begin
      esc_n = 2'd0;
    end else if ((b < sdss_pkg::CH_SPACE) && (b != sdss_pkg::CH_ESC)) begin
      esc_n = 2'd1;
    end else if ((b == sdss_pkg::CH_UP_P) || (b == sdss_pkg::CH_LBRK)) begin
      esc_hdr  = 1'b1;
      esc_mode = (b == sdss_pkg::CH_UP_P) ? sdss_pkg::MODE_DCS : sdss_pkg::MODE_CSI;
    end else if (b != sdss_pkg::CH_ESC) begin
      esc_mode = sdss_pkg::MODE_NORMAL;
      if (b == sdss_pkg::CH_LOW_C) begin
        esc_res[0] = sdss_pkg::ev_res(sdss_pkg::EV_RESET);
        esc_res[1] = sdss_pkg::vt_res(sdss_pkg::CH_ESC);
        esc_res[2] = sdss_pkg::vt_res(b);
        esc_n      = 2'd3;
      end else begin
        esc_res[0] = sdss_pkg::vt_res(sdss_pkg::CH_ESC);
        esc_res[1] = sdss_pkg::vt_res(b);
        esc_n      = 2'd2;
      end
    end
  end

  // per-item decode: result plan and next parser state
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pre_d[i] = sdss_pkg::vt_res(b);
    end
    post_d    = sdss_pkg::vt_res(b);
    npre_d    = 3'd0;
    nflush_d  = '0;
    fl_pay_d  = 1'b0;
    post_v_d  = 1'b0;
    wr_en_d   = 1'b0;
    wr_addr_d = hc_r[sdss_pkg::HDR_AW-1:0];
    wr_data_d = b;
    wr2_d     = 1'b0;
    mode_nxt  = mode_r;
    hc_nxt    = hc_r;
    pc_nxt    = pc_r;
    drop_nxt  = drop_r;
    unique case (mode_r)
      sdss_pkg::MODE_ESC: begin
        pre_d[0] = esc_res[0];
        pre_d[1] = esc_res[1];
        pre_d[2] = esc_res[2];
        npre_d   = {1'b0, esc_n};
        mode_nxt = esc_mode;
        if (esc_hdr) begin
          wr_en_d   = 1'b1;
          wr_addr_d = '0;
          wr_data_d = sdss_pkg::CH_ESC;
          wr2_d     = 1'b1;
          hc_nxt    = sdss_pkg::HC_W'(2);
        end
      end
      sdss_pkg::MODE_CSI: begin
        if (b == sdss_pkg::CH_ESC) begin
          nflush_d = hc_r;
          hc_nxt   = '0;
          mode_nxt = sdss_pkg::MODE_ESC;
        end else if ((hc_r >= sdss_pkg::HC_W'(sdss_pkg::HEADER_BYTES)) ||
                     (b == sdss_pkg::CH_CAN) || (b == sdss_pkg::CH_SUB)) begin
          nflush_d = hc_r;
          post_v_d = 1'b1;
          hc_nxt   = '0;
          mode_nxt = sdss_pkg::MODE_NORMAL;
        end else if (b < sdss_pkg::CH_SPACE) begin
          npre_d = 3'd1;
        end else if (b != sdss_pkg::CH_DEL) begin
          wr_en_d = 1'b1;
          hc_nxt  = hc_inc;
          if ((b >= sdss_pkg::CH_FIN_LO) && (b <= sdss_pkg::CH_FIN_HI)) begin
            // final byte: control done, then the whole sequence to VT
            pre_d[0] = sdss_pkg::ev_res(sdss_pkg::EV_CTRL_DONE);
            npre_d   = 3'd1;
            nflush_d = hc_inc;
            hc_nxt   = '0;
            mode_nxt = sdss_pkg::MODE_NORMAL;
          end
        end
      end
      sdss_pkg::MODE_DCS: begin
        if (b == sdss_pkg::CH_ESC) begin
          hc_nxt   = '0;
          mode_nxt = sdss_pkg::MODE_ESC;
        end else if ((b == sdss_pkg::CH_CAN) || (b == sdss_pkg::CH_SUB) ||
                     (b == sdss_pkg::CH_ST)) begin
          hc_nxt   = '0;
          mode_nxt = sdss_pkg::MODE_NORMAL;
        end else if (b < sdss_pkg::CH_SPACE) begin
          npre_d = 3'd1;
        end else if (b == sdss_pkg::CH_DEL) begin
          npre_d = 3'd0;
        end else if (hc_r < sdss_pkg::HC_W'(sdss_pkg::HEADER_BYTES)) begin
          wr_en_d = 1'b1;
          hc_nxt  = hc_inc;
          if (b == sdss_pkg::CH_LOW_Q) begin
            // sixel image opens; header goes out as payload unless too large
            mode_nxt = sdss_pkg::MODE_SIX;
            hc_nxt   = '0;
            if (hc_inc_ext > eff) begin
              drop_nxt = 1'b1;
              pc_nxt   = '0;
            end else begin
              drop_nxt = 1'b0;
              nflush_d = hc_inc;
              fl_pay_d = 1'b1;
              pc_nxt   = hc_inc_ext;
            end
          end else if (!is_param) begin
            nflush_d = hc_inc;
            hc_nxt   = '0;
            mode_nxt = sdss_pkg::MODE_NORMAL;
          end
        end else begin
          nflush_d = hc_r;
          post_v_d = 1'b1;
          hc_nxt   = '0;
          mode_nxt = sdss_pkg::MODE_NORMAL;
        end
      end
      sdss_pkg::MODE_SIX: begin
        if ((b == sdss_pkg::CH_CAN) || (b == sdss_pkg::CH_SUB)) begin
          pre_d[0] = sdss_pkg::ev_res(sdss_pkg::EV_CANCEL);
          npre_d   = 3'd1;
          pc_nxt   = '0;
          drop_nxt = 1'b0;
          mode_nxt = sdss_pkg::MODE_NORMAL;
        end else begin
          pre_d[0] = pa_emit ? sdss_pkg::pay_res(b) : sdss_pkg::ev_res(close_ev);
          pre_d[1] = sdss_pkg::ev_res(close_ev);
          npre_d   = {2'b00, pa_emit};
          pc_nxt   = pa_pc;
          drop_nxt = pa_drop;
          if (b == sdss_pkg::CH_ESC) begin
            mode_nxt = sdss_pkg::MODE_SIXESC;
          end else if (b == sdss_pkg::CH_ST) begin
            npre_d   = pa_emit ? 3'd2 : 3'd1;
            pc_nxt   = '0;
            drop_nxt = 1'b0;
            mode_nxt = sdss_pkg::MODE_NORMAL;
          end
        end
      end
      sdss_pkg::MODE_SIXESC: begin
        if (b == sdss_pkg::CH_BSLASH) begin
          pre_d[0] = pa_emit ? sdss_pkg::pay_res(b) : sdss_pkg::ev_res(close_ev);
          pre_d[1] = sdss_pkg::ev_res(close_ev);
          npre_d   = pa_emit ? 3'd2 : 3'd1;
          pc_nxt   = '0;
          drop_nxt = 1'b0;
          mode_nxt = sdss_pkg::MODE_NORMAL;
        end else begin
          // cancelled, then the byte is taken as the byte after ESC
          pre_d[0] = sdss_pkg::ev_res(sdss_pkg::EV_CANCEL);
          pre_d[1] = esc_res[0];
          pre_d[2] = esc_res[1];
          pre_d[3] = esc_res[2];
          npre_d   = {1'b0, esc_n} + 3'd1;
          pc_nxt   = '0;
          drop_nxt = 1'b0;
          mode_nxt = esc_mode;
          if (esc_hdr) begin
            wr_en_d   = 1'b1;
            wr_addr_d = '0;
            wr_data_d = sdss_pkg::CH_ESC;
            wr2_d     = 1'b1;
            hc_nxt    = sdss_pkg::HC_W'(2);
          end
        end
      end
      default: begin
        // normal mode, and the unused codes
        mode_nxt = sdss_pkg::MODE_NORMAL;
        if (!vt_ground) begin
          npre_d = 3'd1;
        end else if (b == sdss_pkg::CH_ESC) begin
          mode_nxt = sdss_pkg::MODE_ESC;
        end else if ((b == sdss_pkg::CH_DCS) || (b == sdss_pkg::CH_CSI)) begin
          wr_en_d   = 1'b1;
          wr_addr_d = '0;
          hc_nxt    = sdss_pkg::HC_W'(1);
          mode_nxt  = (b == sdss_pkg::CH_DCS) ? sdss_pkg::MODE_DCS : sdss_pkg::MODE_CSI;
        end else begin
          npre_d = 3'd1;
        end
      end
    endcase
  end

  // plan to the controller
  assign sts.plan.npre   = npre_d;
  assign sts.plan.nflush = nflush_d;
  assign sts.plan.post_v = post_v_d;
  assign sts.plan.wr2    = wr2_d;
  assign sts.out_free    = !out_valid_r || out_ready;

  // header RAM write: decode write at accept, second header byte later
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_d;
    ram_wdata = wr_data_d;
    if (cmd.wr2) begin
      ram_we    = 1'b1;
      ram_waddr = sdss_pkg::HDR_AW'(1);
      ram_wdata = byte_r;
    end else if (cmd.accept) begin
      ram_we = wr_en_d;
    end
  end

  sdss_ram #(
    .WIDTH (8),
    .DEPTH (sdss_pkg::HEADER_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cmd.rd_addr),
    .rdata (ram_rdata)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sdss_pkg::MODE_NORMAL;
      hc_r   <= '0;
      pc_r   <= '0;
      drop_r <= 1'b0;
    end else if (cmd.accept) begin
      mode_r <= mode_nxt;
      hc_r   <= hc_nxt;
      pc_r   <= pc_nxt;
      drop_r <= drop_nxt;
    end
  end

  // plan payload of the current item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < 4; i++) begin
        pre_r[i] <= pre_d[i];
      end
      post_r   <= post_d;
      fl_pay_r <= fl_pay_d;
      byte_r   <= b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= cmd.last;
      case (cmd.sel)
        sdss_pkg::SEL_PRE:   out_res_r <= pre_r[cmd.pre_idx];
        sdss_pkg::SEL_FLUSH: out_res_r <= fl_pay_r ? sdss_pkg::pay_res(ram_rdata) :
                                                     sdss_pkg::vt_res(ram_rdata);
        default:             out_res_r <= post_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign route     = out_res_r.route;
  assign out_byte  = out_res_r.out_byte;
  assign event_res = out_res_r.event_res;
  assign last      = out_last_r;

  // configuration register
  assign cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel_limit = (cfg_paddr[sdss_pkg::CFG_AW-1:2] == sdss_pkg::REG_PAYLOAD_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sdss_pkg::LIMIT_RESET;
    end else if (cfg_wr && cfg_sel_limit) begin
      limit_r <= cfg_pwdata[sdss_pkg::LIMIT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_limit ?
                      {{(sdss_pkg::CFG_DW - sdss_pkg::LIMIT_W){1'b0}}, limit_r} : '0;

endmodule

>>> hw/rtl/sixel_dcs_stream_splitter_core.sv
// ---------------------------------------------------------------------------
// sixel_dcs_stream_splitter_core
// Splits a terminal byte stream into VT bytes, sixel payload and events.
// ---------------------------------------------------------------------------
// One item is taken at a time. Once it is accepted, its results follow one
// at a time. Each byte of a flushed header first passes through S_RD, as the
// header RAM read is registered, and is then sent from S_FL; ESC P / ESC [
// pass through S_WR2 for the second header write before any results. The
// result channel holding ready low stalls the results. The result register
// lets the next item be accepted while the last result still waits.
// payload_limit sits at byte address 0 of the APB port; pready is always high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sixel_dcs_stream_splitter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  sdss_in_if.sink                        in_ch,
  sdss_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sdss_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [sdss_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [sdss_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  sdss_pkg::cmd_t cmd;
  sdss_pkg::sts_t sts;
  logic           in_ready;
  logic           in_acc;

  assign cfg_pready  = 1'b1;
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  // sequencer
  sdss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parser state, header store and result register
  sdss_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_ch.data_byte),
    .vt_ground   (in_ch.vt_ground),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .route       (out_ch.route),
    .out_byte    (out_ch.out_byte),
    .event_res   (out_ch.event_res),
    .last        (out_ch.last),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cmd         (cmd),
    .sts         (sts)
  );

  // results are only produced after the item is in
  `SDSS_ASSERT_IMP(a_no_emit_on_accept, in_acc, !cmd.emit)
  // a result never overwrites one still waiting
  `SDSS_ASSERT_IMP(a_emit_has_room, cmd.emit, !out_ch.valid || out_ch.ready)
  // after the last result of an item the next item can be taken
  `SDSS_ASSERT_NXT(a_ready_after_last, cmd.emit && cmd.last, in_ready)

endmodule
